// ===== rtl/vapr_pkg.sv =====
// Shared types and constants for the VLAN proxy ARP responder.
`timescale 1ns / 1ps
package vapr_pkg;

    // Request kinds carried in req_type; the fourth code is unused.
    localparam logic [1:0] REQ_REQUESTER = 2'd0;
    localparam logic [1:0] REQ_RESPONDER = 2'd1;
    localparam logic [1:0] REQ_RULE      = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_REQUESTER_MAC     = 2'd0;
    localparam logic [1:0] CFG_RESPONDER_MAC     = 2'd1;
    localparam logic [1:0] CFG_REQUESTER_IFINDEX = 2'd2;

    localparam logic [11:0] UNTAGGED_VID  = 12'hFFF;
    localparam logic [15:0] VLAN_TPID     = 16'h8100;
    localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
    localparam int          META_NONE_BIT = 12;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_REPLY   = 2'd2,
        ACT_NEIGH   = 2'd3
    } vapr_action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } vapr_state_t;

    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [15:0] ifindex;
    } vapr_rule_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic ready;
        logic capture;
        logic lookup;
        logic load;
    } vapr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } vapr_sts_t;

endpackage

// ===== rtl/vlan_arp_proxy_responder.sv =====
// Top level of the VLAN proxy ARP responder.
`timescale 1ns / 1ps
// The block takes one word per request (a parsed ARP frame from the requester
// port, a parsed frame from the responder port, or a rule write) and gives
// exactly one result word for each. After reset it runs a clearing pass over
// the rule memory, one entry per cycle, and holds req_stall high throughout;
// configuration writes are to be made only during that pass or while the
// block is idle, which the block itself does not enforce. Each word then
// passes through capture, a read of the rule memory through its registered
// read port, and evaluation into the result register; the next word is not
// taken before that load. The result register sits between the
// two sides, so the next word is accepted while a finished result still waits
// on rsp_stall; a result that waits longer holds the evaluation step until it
// is taken. Requester frames whose ARP sender is the requester port's own
// address are forwarded with the responder's address and a zero sender IP;
// others are answered when their masked target IP hits the VLAN's rule.
// Frames go out tagged unless the VLAN is the untagged one (4095), and
// unused result fields read as zero.
module vlan_arp_proxy_responder
#(
    parameter int VLAN_ENTRIES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // Request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [12:0] vlan_meta,
    input  logic [47:0] eth_dst_mac,
    input  logic [47:0] eth_src_mac,
    input  logic [31:0] type_and_tag,
    input  logic [15:0] arp_op,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [47:0] target_mac,
    input  logic [31:0] target_ip,
    input  logic [63:0] rule_subnet_mask,
    input  logic [15:0] rule_ifindex,
    // Result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  action,
    output logic [47:0] out_eth_dst,
    output logic [47:0] out_eth_src,
    output logic        out_tagged,
    output logic [11:0] out_vid,
    output logic [15:0] out_arp_op,
    output logic [47:0] out_sender_mac,
    output logic [31:0] out_sender_ip,
    output logic [47:0] out_target_mac,
    output logic [31:0] out_target_ip,
    output logic [15:0] out_ifindex
);
    import vapr_pkg::*;

    vapr_cmd_t cmd;
    vapr_sts_t sts;

    // The controller decides when a word may enter; the request channel is
    // stalled whenever it is not waiting for one.
    assign req_stall = !cmd.ready;

    vapr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    vapr_datapath
    #(
        .VLAN_ENTRIES (VLAN_ENTRIES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .vlan_meta        (vlan_meta),
        .eth_dst_mac      (eth_dst_mac),
        .eth_src_mac      (eth_src_mac),
        .type_and_tag     (type_and_tag),
        .arp_op           (arp_op),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_mac       (target_mac),
        .target_ip        (target_ip),
        .rule_subnet_mask (rule_subnet_mask),
        .rule_ifindex     (rule_ifindex),
        .rsp_stall        (rsp_stall),
        .rsp_valid        (rsp_valid),
        .action           (action),
        .out_eth_dst      (out_eth_dst),
        .out_eth_src      (out_eth_src),
        .out_tagged       (out_tagged),
        .out_vid          (out_vid),
        .out_arp_op       (out_arp_op),
        .out_sender_mac   (out_sender_mac),
        .out_sender_ip    (out_sender_ip),
        .out_target_mac   (out_target_mac),
        .out_target_ip    (out_target_ip),
        .out_ifindex      (out_ifindex)
    );

endmodule

// ===== rtl/vapr_ctrl.sv =====
// Controller state machine sequencing table clear, capture, lookup and result load.
`timescale 1ns / 1ps
module vapr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  vapr_pkg::vapr_sts_t sts,
    output vapr_pkg::vapr_cmd_t cmd
);
    import vapr_pkg::*;

    vapr_state_t state_reg;
    vapr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_READ:
            begin
                cmd.lookup = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A captured word is always looked up in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.capture |=> cmd.lookup)
        else $error("capture not followed by lookup");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |-> sts.out_free)
        else $error("result loaded over a waiting result");

    // The clearing pass runs to the last entry before anything is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_CLEAR && !sts.clear_last) |=> !cmd.ready)
        else $error("clearing pass cut short");

endmodule

// ===== rtl/vapr_datapath.sv =====
// Datapath: configuration registers, rule memory, input capture and result register.
`timescale 1ns / 1ps
module vapr_datapath
#(
    parameter int VLAN_ENTRIES = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  vapr_pkg::vapr_cmd_t cmd,
    output vapr_pkg::vapr_sts_t sts,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic [1:0]          req_type,
    input  logic [12:0]         vlan_meta,
    input  logic [47:0]         eth_dst_mac,
    input  logic [47:0]         eth_src_mac,
    input  logic [31:0]         type_and_tag,
    input  logic [15:0]         arp_op,
    input  logic [47:0]         sender_mac,
    input  logic [31:0]         sender_ip,
    input  logic [47:0]         target_mac,
    input  logic [31:0]         target_ip,
    input  logic [63:0]         rule_subnet_mask,
    input  logic [15:0]         rule_ifindex,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output logic [1:0]          action,
    output logic [47:0]         out_eth_dst,
    output logic [47:0]         out_eth_src,
    output logic                out_tagged,
    output logic [11:0]         out_vid,
    output logic [15:0]         out_arp_op,
    output logic [47:0]         out_sender_mac,
    output logic [31:0]         out_sender_ip,
    output logic [47:0]         out_target_mac,
    output logic [31:0]         out_target_ip,
    output logic [15:0]         out_ifindex
);
    import vapr_pkg::*;

    localparam int          IDX_W      = $clog2(VLAN_ENTRIES);
    localparam logic [12:0] ENTRIES_13 = 13'(VLAN_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VLAN_ENTRIES - 1);

    // Configuration registers.
    logic [47:0] requester_mac_reg;
    logic [47:0] responder_mac_reg;
    logic [15:0] requester_ifindex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requester_mac_reg     <= '0;
            responder_mac_reg     <= '0;
            requester_ifindex_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_REQUESTER_MAC)
            begin
                requester_mac_reg <= cfg_data;
            end
            if (cfg_index == CFG_RESPONDER_MAC)
            begin
                responder_mac_reg <= cfg_data;
            end
            if (cfg_index == CFG_REQUESTER_IFINDEX)
            begin
                requester_ifindex_reg <= cfg_data[15:0];
            end
        end
    end

    // Captured input word.
    logic [1:0]  type_reg;
    logic [12:0] vlan_meta_reg;
    logic [47:0] eth_dst_reg;
    logic [47:0] eth_src_reg;
    logic [31:0] type_and_tag_reg;
    logic [15:0] arp_op_reg;
    logic [47:0] sender_mac_reg;
    logic [31:0] sender_ip_reg;
    logic [47:0] target_mac_reg;
    logic [31:0] target_ip_reg;
    logic [63:0] rule_subnet_mask_reg;
    logic [15:0] rule_ifindex_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg             <= req_type;
            vlan_meta_reg        <= vlan_meta;
            eth_dst_reg          <= eth_dst_mac;
            eth_src_reg          <= eth_src_mac;
            type_and_tag_reg     <= type_and_tag;
            arp_op_reg           <= arp_op;
            sender_mac_reg       <= sender_mac;
            sender_ip_reg        <= sender_ip;
            target_mac_reg       <= target_mac;
            target_ip_reg        <= target_ip;
            rule_subnet_mask_reg <= rule_subnet_mask;
            rule_ifindex_reg     <= rule_ifindex;
        end
    end

    // VLAN selection: metadata wins over the tag, otherwise untagged.
    logic [11:0] vid;
    logic        vid_in_table;

    always_comb
    begin
        vid = UNTAGGED_VID;
        if (type_and_tag_reg[31:16] == VLAN_TPID)
        begin
            vid = type_and_tag_reg[11:0];
        end
        if (!vlan_meta_reg[META_NONE_BIT])
        begin
            vid = vlan_meta_reg[11:0];
        end
    end

    assign vid_in_table = {1'b0, vid} < ENTRIES_13;

    // Clearing pass counter.
    logic [IDX_W-1:0] clear_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
        end
    end

    // Rule memory: one write port, one registered read port.
    vapr_rule_t       rule_mem [VLAN_ENTRIES];
    vapr_rule_t       rd_entry_reg;
    logic             rule_we;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    vapr_rule_t       mem_wdata;

    assign rule_we = cmd.lookup && (type_reg == REQ_RULE)
                     && !vlan_meta_reg[META_NONE_BIT] && (vlan_meta_reg < ENTRIES_13);
    assign mem_we  = cmd.clear_step || rule_we;

    always_comb
    begin
        mem_waddr = vlan_meta_reg[IDX_W-1:0];
        mem_wdata.subnet  = rule_subnet_mask_reg[63:32];
        mem_wdata.mask    = rule_subnet_mask_reg[31:0];
        mem_wdata.ifindex = (vlan_meta_reg[11:0] == UNTAGGED_VID) ? requester_ifindex_reg
                                                                  : rule_ifindex_reg;
        if (cmd.clear_step)
        begin
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rule_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.lookup)
        begin
            rd_entry_reg <= rule_mem[vid[IDX_W-1:0]];
        end
    end

    // Result evaluation.
    vapr_rule_t   entry;
    vapr_action_t res_action;
    logic [47:0]  res_eth_dst;
    logic [47:0]  res_eth_src;
    logic         res_tagged;
    logic [11:0]  res_vid;
    logic [15:0]  res_arp_op;
    logic [47:0]  res_sender_mac;
    logic [31:0]  res_sender_ip;
    logic [47:0]  res_target_mac;
    logic [31:0]  res_target_ip;
    logic [15:0]  res_ifindex;
    logic         rule_hit;

    assign entry    = vid_in_table ? rd_entry_reg : '0;
    assign rule_hit = (entry.subnet != '0) && ((target_ip_reg & entry.mask) == entry.subnet);

    always_comb
    begin
        res_action     = ACT_NONE;
        res_eth_dst    = '0;
        res_eth_src    = '0;
        res_tagged     = 1'b0;
        res_vid        = '0;
        res_arp_op     = '0;
        res_sender_mac = '0;
        res_sender_ip  = '0;
        res_target_mac = '0;
        res_target_ip  = '0;
        res_ifindex    = '0;
        unique case (type_reg)
            REQ_RESPONDER:
            begin
                res_action     = ACT_NEIGH;
                res_sender_mac = sender_mac_reg;
                res_sender_ip  = sender_ip_reg;
                res_ifindex    = entry.ifindex;
            end
            REQ_REQUESTER:
            begin
                priority if (sender_mac_reg == requester_mac_reg)
                begin
                    res_action     = ACT_FORWARD;
                    res_eth_dst    = eth_dst_reg;
                    res_eth_src    = responder_mac_reg;
                    res_arp_op     = arp_op_reg;
                    res_sender_mac = responder_mac_reg;
                    res_target_mac = target_mac_reg;
                    res_target_ip  = target_ip_reg;
                end
                else if (rule_hit)
                begin
                    res_action     = ACT_REPLY;
                    res_eth_dst    = eth_src_reg;
                    res_eth_src    = requester_mac_reg;
                    res_arp_op     = ARP_OP_REPLY;
                    res_sender_mac = requester_mac_reg;
                    res_sender_ip  = target_ip_reg;
                    res_target_mac = sender_mac_reg;
                    res_target_ip  = sender_ip_reg;
                end
                else
                begin
                    res_action = ACT_NONE;
                end
                if (res_action != ACT_NONE && vid != UNTAGGED_VID)
                begin
                    res_tagged = 1'b1;
                    res_vid    = vid;
                end
            end
            default:
            begin
                res_action = ACT_NONE;
            end
        endcase
    end

    // Output register.
    logic         out_valid_reg;
    vapr_action_t out_action_reg;
    logic [47:0]  out_eth_dst_reg;
    logic [47:0]  out_eth_src_reg;
    logic         out_tagged_reg;
    logic [11:0]  out_vid_reg;
    logic [15:0]  out_arp_op_reg;
    logic [47:0]  out_sender_mac_reg;
    logic [31:0]  out_sender_ip_reg;
    logic [47:0]  out_target_mac_reg;
    logic [31:0]  out_target_ip_reg;
    logic [15:0]  out_ifindex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_action_reg     <= res_action;
            out_eth_dst_reg    <= res_eth_dst;
            out_eth_src_reg    <= res_eth_src;
            out_tagged_reg     <= res_tagged;
            out_vid_reg        <= res_vid;
            out_arp_op_reg     <= res_arp_op;
            out_sender_mac_reg <= res_sender_mac;
            out_sender_ip_reg  <= res_sender_ip;
            out_target_mac_reg <= res_target_mac;
            out_target_ip_reg  <= res_target_ip;
            out_ifindex_reg    <= res_ifindex;
        end
    end

    assign sts.clear_last = (clear_idx_reg == LAST_IDX);
    assign sts.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid      = out_valid_reg;
    assign action         = out_action_reg;
    assign out_eth_dst    = out_eth_dst_reg;
    assign out_eth_src    = out_eth_src_reg;
    assign out_tagged     = out_tagged_reg;
    assign out_vid        = out_vid_reg;
    assign out_arp_op     = out_arp_op_reg;
    assign out_sender_mac = out_sender_mac_reg;
    assign out_sender_ip  = out_sender_ip_reg;
    assign out_target_mac = out_target_mac_reg;
    assign out_target_ip  = out_target_ip_reg;
    assign out_ifindex    = out_ifindex_reg;

    // A rule write never competes with the clearing pass for the write port.
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.clear_step && rule_we))
        else $error("rule write during clearing pass");

    // An untagged result carries no VLAN id.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && !out_tagged_reg) |-> (out_vid_reg == '0))
        else $error("VLAN id on untagged result");

endmodule
